@@ design/sarpc_pkg.sv @@
// Shared types and constants for the servo angle ramp to PWM compare block.
`default_nettype none

package sarpc_pkg;

  // Angle limits
  localparam logic [7:0] MAX_ANGLE    = 8'd180;
  localparam logic [7:0] UNPOSITIONED = 8'd255;

  // Command kinds
  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_RAMP = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [1:0] REG_PWM_PERIOD = 2'd2;
  localparam logic [1:0] REG_TIMER_PERIOD = 2'd3;

  // Configuration reset values
  localparam logic [15:0] RST_MIN_PULSE    = 16'd1000;
  localparam logic [15:0] RST_MAX_PULSE    = 16'd2000;
  localparam logic [15:0] RST_PWM_PERIOD   = 16'd20000;
  localparam logic [15:0] RST_TIMER_PERIOD = 16'd65535;

  // Serial divider geometry
  localparam int CFG_W     = 16;
  localparam int DIVW      = 34;  // timer_period * (min + angle * inc)
  localparam int CNT_W     = $clog2(DIVW);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVW - 1);

  // Reciprocal of 180 for a 16-bit span: floor(x / 180) = (x * 93207) >> 24
  localparam logic [16:0] INC_RECIP = 17'd93207;
  localparam int          INC_SHIFT = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take the input transaction, update angle state
    logic div_step;  // one restoring division step
    logic mul_a;     // min + angle * inc
    logic mul_b;     // timer_period * sum, load divider
    logic fin;       // saturate quotient into duty compare
    logic load_out;  // load the result register
  } sarpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_compute;  // the offered transaction sets a new position
  } sarpc_status_t;

endpackage

`default_nettype wire

@@ design/sarpc_ctrl.sv @@
// Controller state machine: sequences the divider, multiplies and result handshake.
`default_nettype none

module sarpc_ctrl
  import sarpc_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire sarpc_status_t status_i,
  output sarpc_cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  // Decode commands and next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (status_i.need_compute) begin
            state_d = ST_MULA;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MULB;
      end
      ST_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_DIV;
        cnt_d       = DIV_LAST;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold or release the output transaction
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/sarpc_dp.sv @@
// Datapath: configuration, angle and ramp state, serial divider, multiplies, result register.
`default_nettype none

module sarpc_dp
  import sarpc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic [1:0]        kind_i,
  input  wire logic [7:0]        angle_i,
  input  wire logic [7:0]        step_deg_i,
  input  wire sarpc_cmd_t        cmd_i,
  output sarpc_status_t          status_o,
  output logic [31:0]            compare_value_o,
  output logic                   compare_written_o,
  output logic [7:0]             position_o,
  output logic                   ramping_o,
  output logic                   rejected_o
);

  // Configuration registers
  logic [CFG_W-1:0] min_q, max_q, pwm_q, timer_q;

  // Angle and ramp state
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  target_q, target_d;
  logic [7:0]  step_q, step_d;
  logic        active_q, active_d;
  logic [31:0] duty_q;
  logic        wr_q, wr_d;
  logic        rej_q, rej_d;

  // Arithmetic registers
  logic [DIVW-1:0] q_q;
  logic [15:0]     rem_q;
  logic [17:0]     sum_q;

  // Result register
  logic [31:0] res_compare_q;
  logic        res_written_q;
  logic [7:0]  res_position_q;
  logic        res_ramping_q;
  logic        res_rejected_q;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= RST_MIN_PULSE;
      max_q   <= RST_MAX_PULSE;
      pwm_q   <= RST_PWM_PERIOD;
      timer_q <= RST_TIMER_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MIN_PULSE:    min_q   <= cfg_wdata_i;
        REG_MAX_PULSE:    max_q   <= cfg_wdata_i;
        REG_PWM_PERIOD:   pwm_q   <= cfg_wdata_i;
        REG_TIMER_PERIOD: timer_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Pick the next ramp position
  logic [7:0] up_gap, down_gap, next_pos;
  assign up_gap   = target_q - cur_q;
  assign down_gap = cur_q - target_q;

  always_comb begin
    if (cur_q == UNPOSITIONED) begin
      next_pos = target_q;
    end else if (target_q > cur_q) begin
      next_pos = (up_gap <= step_q) ? target_q : cur_q + step_q;
    end else begin
      next_pos = (down_gap <= step_q) ? target_q : cur_q - step_q;
    end
  end

  // Decode the offered transaction against the current state
  logic angle_bad;
  assign angle_bad = (angle_i > MAX_ANGLE) || (angle_i == cur_q);

  always_comb begin
    cur_d    = cur_q;
    target_d = target_q;
    step_d   = step_q;
    active_d = active_q;
    wr_d     = 1'b0;
    rej_d    = 1'b0;
    case (kind_i)
      KIND_MOVE: begin
        if (angle_bad) begin
          rej_d = 1'b1;
        end else begin
          cur_d    = angle_i;
          active_d = 1'b0;
          wr_d     = 1'b1;
        end
      end
      KIND_RAMP: begin
        if (angle_bad) begin
          rej_d = 1'b1;
        end else begin
          target_d = angle_i;
          step_d   = (step_deg_i == '0) ? 8'd1 : step_deg_i;
          active_d = 1'b1;
        end
      end
      KIND_TICK: begin
        if (active_q) begin
          cur_d    = next_pos;
          active_d = (next_pos != target_q);
          wr_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.need_compute = wr_d;

  // Quotient saturated to 32 bits; zero period gives all ones
  logic [31:0] duty_new;
  assign duty_new = ((pwm_q == '0) || (q_q[DIVW-1:32] != '0)) ? '1 : q_q[31:0];

  // Update angle state on acceptance, duty at the end of the computation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= UNPOSITIONED;
      target_q <= '0;
      step_q   <= 8'd1;
      active_q <= 1'b0;
      duty_q   <= '0;
      wr_q     <= 1'b0;
      rej_q    <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cur_q    <= cur_d;
        target_q <= target_d;
        step_q   <= step_d;
        active_q <= active_d;
        wr_q     <= wr_d;
        rej_q    <= rej_d;
      end
      if (cmd_i.fin) begin
        duty_q <= duty_new;
      end
    end
  end

  // Restoring division step by pwm_period_us, one quotient bit per cycle
  logic [16:0] divisor;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [16:0] rem_sub;
  assign divisor = {1'b0, pwm_q};
  assign rem_sh  = {rem_q, q_q[DIVW-1]};
  assign rem_ge  = (rem_sh >= divisor);
  assign rem_sub = rem_sh - divisor;

  // Pulse increment per degree by reciprocal multiply, zero when max is below min
  logic [15:0] pulse_span;
  logic [32:0] span_recip;
  logic [8:0]  inc_calc;
  assign pulse_span = (max_q >= min_q) ? (max_q - min_q) : '0;
  assign span_recip = {17'd0, pulse_span} * {16'd0, INC_RECIP};
  assign inc_calc   = span_recip[INC_SHIFT+8:INC_SHIFT];

  // Multiplies
  logic [16:0]     ang_inc;
  logic [17:0]     sum_d;
  logic [DIVW-1:0] prod;
  assign ang_inc = {9'd0, cur_q} * {8'd0, q_q[8:0]};
  assign sum_d   = {1'b0, ang_inc} + {2'd0, min_q};
  assign prod    = {18'd0, timer_q} * {16'd0, sum_q};

  // Advance the divider and multiply registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      q_q   <= {{(DIVW - 9){1'b0}}, inc_calc};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      q_q   <= {q_q[DIVW-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
    end else if (cmd_i.mul_b) begin
      q_q   <= prod;
      rem_q <= '0;
    end
    if (cmd_i.mul_a) begin
      sum_q <= sum_d;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_compare_q  <= duty_q;
      res_written_q  <= wr_q;
      res_position_q <= cur_q;
      res_ramping_q  <= active_q;
      res_rejected_q <= rej_q;
    end
  end

  assign compare_value_o   = res_compare_q;
  assign compare_written_o = res_written_q;
  assign position_o        = res_position_q;
  assign ramping_o         = res_ramping_q;
  assign rejected_o        = res_rejected_q;

endmodule

`default_nettype wire

@@ design/servo_angle_ramp_to_pwm_compare.sv @@
// Top level of the servo angle ramp to PWM compare block.
`default_nettype none

// Takes move, ramp-start and ramp-tick commands, tracks the servo angle and
// gives the PWM output compare value timer_period * (min + angle * inc) /
// pwm_period_us, saturated to 32 bits, with inc = (max - min) / 180.
// One transaction is worked on at a time. A command that sets a new
// position (an accepted move, or a tick while a ramp runs) raises
// out_valid_o after these steps: inc comes from a reciprocal multiply
// at acceptance, then min + angle * inc is formed, the sum is multiplied
// by timer_period, 34 steps of a serial restoring division by
// pwm_period_us follow, the quotient is saturated and the result
// register is loaded. Every other command skips the arithmetic and goes
// straight to loading the result register. A new transaction is accepted
// as soon as the previous result sits in the output register, even if it
// has not been taken yet; a result still waiting when the next one is
// ready stalls the block until it is taken. The user must write
// configuration via cfg_we_i only while idle, which is not enforced.

module servo_angle_ramp_to_pwm_compare
  import sarpc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       kind_i,
  input  wire logic [7:0]       angle_i,
  input  wire logic [7:0]       step_deg_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [31:0]           compare_value_o,
  output logic                  compare_written_o,
  output logic [7:0]            position_o,
  output logic                  ramping_o,
  output logic                  rejected_o
);

  sarpc_cmd_t    cmd;
  sarpc_status_t status;

  // Sequence each transaction
  sarpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold state and do the arithmetic
  sarpc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .angle_i           (angle_i),
    .step_deg_i        (step_deg_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .compare_value_o   (compare_value_o),
    .compare_written_o (compare_written_o),
    .position_o        (position_o),
    .ramping_o         (ramping_o),
    .rejected_o        (rejected_o)
  );

endmodule

`default_nettype wire
